/* hw/rtl/dspq_pkg.sv */
// ============================================================================
// dspq_pkg: shared types and constants
// Default sizes, operation, status and order-mode codes plus the sequencer state type.
// ============================================================================
`default_nettype none
package dspq_pkg;
    localparam int CAPACITY_DEF = 32;
    localparam int ID_BITS_DEF  = 8;
    localparam int KEY_BITS_DEF = 16;

    localparam logic OP_ADD     = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_EXTRACTED = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    localparam logic [1:0] MODE_STACK = 2'd0;
    localparam logic [1:0] MODE_ASC   = 2'd1;
    localparam logic [1:0] MODE_DESC  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,   // wait for a transaction
        S_SCAN,   // read entries looking for the id and the insert place
        S_PLAN,   // choose the run of entries to move
        S_DELETE, // shift a run of entries down by one slot
        S_INSERT, // shift a run of entries up by one slot
        S_WRITE,  // write the new entry
        S_OUT     // hand the result to the output register
    } t_state;
endpackage
`default_nettype wire

/* hw/rtl/dspq_if.sv */
// ============================================================================
// dspq_in_if / dspq_out_if: valid-ready channels of the queue
// One input transaction carries an operation; one result transaction a status.
// ============================================================================
`default_nettype none
interface dspq_in_if #(parameter int ID_BITS = 8, parameter int KEY_BITS = 16);
    logic                valid;
    logic                ready;
    logic                operation;
    logic [ID_BITS-1:0]  node_id;
    logic [KEY_BITS-1:0] key_distance;
    modport source (output valid, operation, node_id, key_distance, input ready);
    modport sink   (input valid, operation, node_id, key_distance, output ready);
endinterface

interface dspq_out_if #(parameter int ID_BITS = 8, parameter int KEY_BITS = 16);
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic [ID_BITS-1:0]  out_id;
    logic [KEY_BITS-1:0] out_distance;
    modport source (output valid, status, out_id, out_distance, input ready);
    modport sink   (input valid, status, out_id, out_distance, output ready);
endinterface
`default_nettype wire

/* hw/rtl/dedup_sorted_priority_queue_unit.sv */
// ============================================================================
// dedup_sorted_priority_queue_unit: deduplicating bounded priority queue
// Sorted (or stack) queue of (id, distance) entries kept in one memory.
// ============================================================================
// The queue holds up to CAPACITY entries in a single synchronous memory, slot 0
// being the front. Every transaction is handled by a sequencer that walks the
// memory one slot per cycle through its single registered read port and its
// single write port. An add scans the stored entries to find the matching id
// and the insert position, plans the move, then shifts only the entries
// between the old slot (or the back) and the new one, one per cycle, and
// writes the new entry; a new id that finds the queue full is dropped. An
// extract reads the front slot, plans and shifts the remaining entries down.
// The finished result goes to an output register and the sequencer returns to
// idle, so the next transaction can be taken while the result waits. While the
// output register is still full the sequencer waits with its result and the
// input stays stalled. The order mode register may be written only while the
// block is idle. There is no clearing pass: unwritten slots are never read
// because the fill count bounds every walk.
// ============================================================================
`default_nettype none
module dedup_sorted_priority_queue_unit
    import dspq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_BITS  = ID_BITS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    dspq_in_if.sink         i_in,
    dspq_out_if.source      o_out
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ID_BITS + KEY_BITS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // Entry memory: id in the upper bits, key in the lower bits.
    logic [EW-1:0] mem [CAPACITY];
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
    end

    t_state r_state, n_state;
    logic [1:0]          r_mode;
    logic [CW-1:0]       r_fill, n_fill;
    logic                r_op;
    logic [ID_BITS-1:0]  r_id;
    logic [KEY_BITS-1:0] r_key;
    // r_idx: next slot to read; r_end: last slot to read in this walk;
    // r_chk: slot whose data is in r_rdata this cycle.
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_end, n_end;
    logic                r_issue, n_issue;
    logic [CW-1:0]       r_chk, n_chk;
    logic                r_chkv, n_chkv;
    logic                r_found, n_found;
    logic [CW-1:0]       r_fpos, n_fpos;
    logic                r_pfound, n_pfound;
    logic [CW-1:0]       r_ppos, n_ppos;
    logic [CW-1:0]       r_wpos, n_wpos;
    logic [2:0]          r_status, n_status;
    logic [ID_BITS-1:0]  r_oid, n_oid;
    logic [KEY_BITS-1:0] r_okey, n_okey;

    // Output register, which lets the sequencer go back to idle while a
    // result waits to be taken.
    logic                r_ovalid, n_ovalid;
    logic [2:0]          r_out_status;
    logic [ID_BITS-1:0]  r_out_id;
    logic [KEY_BITS-1:0] r_out_dist;

    logic [ID_BITS-1:0]  rd_id;
    logic [KEY_BITS-1:0] rd_key;
    logic                rd_beats;
    logic [CW-1:0]       ins_pos; // insert position in the queue after removal
    logic                pass_done;
    logic                drop_full;
    logic                no_move;
    logic                out_load;

    assign rd_id  = r_rdata[EW-1:KEY_BITS];
    assign rd_key = r_rdata[KEY_BITS-1:0];
    always_comb begin
        unique case (r_mode)
            MODE_ASC:  rd_beats = r_key < rd_key;
            MODE_DESC: rd_beats = r_key > rd_key;
            default:   rd_beats = 1'b0;
        endcase
    end

    // The scan records the first slot that the new key beats in the original
    // order; when the old copy sits in front of it, the place moves one slot lower.
    always_comb begin
        if (r_mode == MODE_STACK) ins_pos = '0;
        else if (!r_pfound) ins_pos = r_fill - CW'(r_found);
        else if (r_found && r_fpos < r_ppos) ins_pos = r_ppos - ONE_C;
        else ins_pos = r_ppos;
    end

    // The last read of the walk is back from the memory.
    assign pass_done = r_chkv && (r_chk == r_end);
    // A new id finds the queue full.
    assign drop_full = !r_found && (r_fill >= CAP_C);
    // The new entry lands where the old copy was, or at the back of the queue.
    assign no_move   = r_found ? (ins_pos == r_fpos) : (ins_pos == r_fill);
    assign out_load  = (r_state == S_OUT) && (!r_ovalid || o_out.ready);
    assign n_ovalid  = out_load || (r_ovalid && !o_out.ready);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_fill == '0 || pass_done) n_state = S_PLAN;
            end
            S_PLAN: begin
                if (r_op == OP_EXTRACT) n_state = (r_fill <= ONE_C) ? S_OUT : S_DELETE;
                else if (drop_full) n_state = S_OUT;
                else if (no_move) n_state = S_WRITE;
                else if (r_found && ins_pos > r_fpos) n_state = S_DELETE;
                else n_state = S_INSERT;
            end
            S_DELETE: begin
                if (pass_done) n_state = (r_op == OP_EXTRACT) ? S_OUT : S_WRITE;
            end
            S_INSERT: begin
                if (pass_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_fill = r_fill; n_idx = r_idx; n_end = r_end; n_issue = r_issue;
        n_chk = r_chk; n_chkv = 1'b0;
        n_found = r_found; n_fpos = r_fpos; n_pfound = r_pfound; n_ppos = r_ppos;
        n_wpos = r_wpos; n_status = r_status; n_oid = r_oid; n_okey = r_okey;
        mem_we = 1'b0; mem_waddr = '0; mem_wdata = r_rdata; mem_raddr = r_idx[AW-1:0];
        // Every walk issues one read per cycle from r_idx towards r_end.
        if ((r_state == S_SCAN || r_state == S_DELETE || r_state == S_INSERT)
            && r_issue) begin
            n_chkv = 1'b1; n_chk = r_idx;
            if (r_idx == r_end) n_issue = 1'b0;
            else if (r_state == S_INSERT) n_idx = r_idx - ONE_C;
            else n_idx = r_idx + ONE_C;
        end
        unique case (r_state)
            S_IDLE: begin
                // An extract only needs the front slot; an add reads them all.
                n_idx = '0; n_issue = (r_fill != '0);
                n_end = (i_in.operation == OP_EXTRACT) ? '0 : r_fill - ONE_C;
                n_found = 1'b0; n_pfound = 1'b0; n_fpos = '0; n_ppos = '0; n_wpos = '0;
                n_oid = '0; n_okey = '0;
            end
            S_SCAN: begin
                if (r_chkv) begin
                    if (rd_id == r_id) begin
                        n_found = 1'b1; n_fpos = r_chk;
                    end else if (!r_pfound && rd_beats) begin
                        n_pfound = 1'b1; n_ppos = r_chk;
                    end
                    if (r_op == OP_EXTRACT) begin
                        n_oid = rd_id; n_okey = rd_key;
                    end
                end
            end
            S_PLAN: begin
                n_wpos = ins_pos;
                if (r_op == OP_EXTRACT) begin
                    if (r_fill == '0) begin
                        n_status = ST_EMPTY;
                    end else if (r_fill == ONE_C) begin
                        n_fill = '0; n_status = ST_EXTRACTED;
                    end else begin
                        n_idx = ONE_C; n_end = r_fill - ONE_C; n_issue = 1'b1;
                    end
                end else if (drop_full) begin
                    n_status = ST_DROPPED;
                end else if (!no_move) begin
                    n_issue = 1'b1; n_end = ins_pos;
                    // Moving back: entries behind the old copy close up to the
                    // new place. Moving forward or new: entries from the new
                    // place up to the old copy (or the back) move up by one.
                    if (r_found && ins_pos > r_fpos) n_idx = r_fpos + ONE_C;
                    else n_idx = (r_found ? r_fpos : r_fill) - ONE_C;
                end
            end
            S_DELETE: begin
                // The slot read last cycle is written one slot lower.
                if (r_chkv) begin
                    mem_we = 1'b1; mem_waddr = AW'(r_chk - ONE_C);
                end
                if (pass_done && r_op == OP_EXTRACT) begin
                    n_fill = r_fill - ONE_C; n_status = ST_EXTRACTED;
                end
            end
            S_INSERT: begin
                // The slot read last cycle is written one slot higher.
                if (r_chkv) begin
                    mem_we = 1'b1; mem_waddr = AW'(r_chk + ONE_C);
                end
            end
            S_WRITE: begin
                mem_we = 1'b1; mem_waddr = r_wpos[AW-1:0]; mem_wdata = {r_id, r_key};
                n_fill = r_fill + CW'(!r_found);
                n_status = r_found ? ST_REPLACED : ST_ADDED;
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_ASC;
            r_fill   <= '0;
            r_chkv   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) r_mode <= i_cfg_wdata;
            r_fill   <= n_fill;
            r_chkv   <= n_chkv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_op <= i_in.operation; r_id <= i_in.node_id; r_key <= i_in.key_distance;
        end
        r_idx <= n_idx; r_end <= n_end; r_issue <= n_issue; r_chk <= n_chk;
        r_found <= n_found; r_fpos <= n_fpos;
        r_pfound <= n_pfound; r_ppos <= n_ppos; r_wpos <= n_wpos; r_status <= n_status;
        r_oid <= n_oid; r_okey <= n_okey;
        if (out_load) begin
            r_out_status <= r_status; r_out_id <= r_oid; r_out_dist <= r_okey;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_out_status;
    assign o_out.out_id       = r_out_id;
    assign o_out.out_distance = r_out_dist;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CAP_C) else $error("fill count above capacity");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.status)
        && $stable(o_out.out_id) && $stable(o_out.out_distance)))
        else $error("result changed while waiting");
    a_fill_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && !r_found) |=> (r_fill == $past(r_fill) + ONE_C))
        else $error("write of a new id did not grow the queue");
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chkv |-> (r_chk < r_fill)) else $error("read outside the occupied slots");
endmodule
`default_nettype wire

/* test/dspq_test_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// dspq_test_pkg: queue model for the priority queue testbench
// Holds the expected queue contents and computes the status of each operation.
// ============================================================================
package dspq_test_pkg;
    import dspq_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_id;
        logic [15:0] out_distance;
    } t_outcome;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] key;
    } t_entry;

    class queue_model;
        t_entry     entries[$];
        logic [1:0] mode;
        int         capacity;

        function new(int cap);
            capacity = cap;
            mode     = MODE_ASC;
        endfunction

        function t_outcome apply(logic op, logic [7:0] id, logic [15:0] key);
            t_outcome res;
            t_entry   ent;
            bit       found;
            int       pos;
            res   = '0;
            found = 0;
            if (op == OP_EXTRACT) begin
                if (entries.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    ent              = entries.pop_front();
                    res.status       = ST_EXTRACTED;
                    res.out_id       = ent.id;
                    res.out_distance = ent.key;
                end
                return res;
            end
            foreach (entries[i]) begin
                if (!found && entries[i].id == id) begin
                    found = 1;
                    entries.delete(i);
                    break;
                end
            end
            if (!found && entries.size() >= capacity) begin
                res.status = ST_DROPPED;
                return res;
            end
            pos = (mode == MODE_STACK) ? 0 : entries.size();
            if (mode == MODE_ASC || mode == MODE_DESC) begin
                foreach (entries[i]) begin
                    if ((mode == MODE_ASC && key < entries[i].key) ||
                        (mode == MODE_DESC && key > entries[i].key)) begin
                        pos = i;
                        break;
                    end
                end
            end
            ent.id  = id;
            ent.key = key;
            entries.insert(pos, ent);
            res.status = found ? ST_REPLACED : ST_ADDED;
            return res;
        endfunction
    endclass
endpackage

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench of the deduplicating priority queue
// Drives a directed table and then random add/extract traffic under all order
// modes, with random idling on both channels, and checks every result
// against a queue model.
// ============================================================================
module tb_top;
    import dspq_pkg::*;
    import dspq_test_pkg::*;

    localparam int CAP = 32;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;

    dspq_in_if  #(.ID_BITS(8), .KEY_BITS(16)) in_ch ();
    dspq_out_if #(.ID_BITS(8), .KEY_BITS(16)) out_ch ();

    dedup_sorted_priority_queue_unit #(.CAPACITY(CAP)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // One row of the directed table. When has_exp is set, the result is also
    // compared with the typed-in value, not only with the model.
    typedef struct {
        logic       op;
        logic [7:0] id;
        logic [15:0] key;
        bit         has_exp;
        t_outcome   exp;
    } t_row;

    queue_model occupancy;
    t_outcome   pending_results[$];
    t_outcome   typed_results[$];
    bit         typed_flags[$];
    int         mismatch_count;
    bit         idle_free;      // no idling on either side while set
    bit         hold_sink;      // asks the receiver for a long hold-off
    bit         holding;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard limit: the worst case at full occupancy plus random stalls stays far
    // below this bound.
    initial begin
        #(20ns * 2_000_000);
        $display("Verification failed");
        $finish;
    end

    function automatic void report_mismatch(string what, t_outcome exp_v, t_outcome act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s mismatch: expected st=%0d id=%0d dist=%0d, %s",
                     $realtime, what, exp_v.status, exp_v.out_id, exp_v.out_distance,
                     $sformatf("got st=%0d id=%0d dist=%0d",
                               act_v.status, act_v.out_id, act_v.out_distance));
    endfunction

    // Receiver: random ready, with an optional long hold-off to fill the block.
    initial begin
        int hold_cycles;
        out_ch.ready = 1'b0;
        holding      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink && !holding) begin
                holding      = 1'b1;
                out_ch.ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < 300; hold_cycles++)
                    @(negedge i_clk);
                holding   = 1'b0;
                hold_sink = 1'b0;
            end
            out_ch.ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 34);
        end
    end

    // Result checker: every transaction on the output side is matched against
    // the oldest prediction, and against the typed value when there is one.
    always @(posedge i_clk) begin
        t_outcome act_v;
        t_outcome exp_v;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            act_v.status       = out_ch.status;
            act_v.out_id       = out_ch.out_id;
            act_v.out_distance = out_ch.out_distance;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected", '0, act_v);
            end else begin
                exp_v = pending_results.pop_front();
                if (act_v !== exp_v)
                    report_mismatch("model", exp_v, act_v);
                if (typed_flags.pop_front()) begin
                    exp_v = typed_results.pop_front();
                    if (act_v !== exp_v)
                        report_mismatch("table", exp_v, act_v);
                end
            end
        end
    end

    // Sends one transaction and records the model's prediction at acceptance.
    // Valid stays high into the next transaction unless the sender idles.
    task automatic send_op(logic op, logic [7:0] id, logic [15:0] key,
                           bit has_exp, t_outcome exp_v);
        if (!idle_free)
            while ($urandom_range(99) < 34) begin
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= op;
        in_ch.node_id      <= id;
        in_ch.key_distance <= key;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(occupancy.apply(op, id, key));
        typed_flags.push_back(has_exp);
        if (has_exp) typed_results.push_back(exp_v);
        @(negedge i_clk);
    endtask

    // Waits for the block to drain before a register write.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic set_mode(logic [1:0] mode_v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode_v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        occupancy.mode = mode_v;
    endtask

    function automatic t_outcome outcome(logic [2:0] st, logic [7:0] id, logic [15:0] dist_v);
        t_outcome r;
        r.status       = st;
        r.out_id       = id;
        r.out_distance = dist_v;
        return r;
    endfunction

    initial begin
        t_row       rows [11];
        int         n;
        int         k;
        int         id_span;
        logic       op;
        logic [7:0] id;
        logic [15:0] key;
        logic [1:0] mode_v;

        occupancy      = new(CAP);
        mismatch_count = 0;
        idle_free      = 1'b0;
        hold_sink      = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        in_ch.valid        = 1'b0;
        in_ch.operation    = OP_ADD;
        in_ch.node_id      = '0;
        in_ch.key_distance = '0;
        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table in the reset mode (ascending). Rows with a typed value
        // are readable at a glance: empty extracts, adds, a replace, ordered extracts.
        rows = '{
            '{OP_EXTRACT, 8'd0,   16'd0,    1'b1, outcome(ST_EMPTY, 8'd0, 16'd0)},
            '{OP_ADD,     8'd255, 16'hFFFF, 1'b1, outcome(ST_ADDED, 8'd0, 16'd0)},
            '{OP_ADD,     8'd0,   16'd0,    1'b1, outcome(ST_ADDED, 8'd0, 16'd0)},
            '{OP_ADD,     8'd7,   16'd100,  1'b1, outcome(ST_ADDED, 8'd0, 16'd0)},
            '{OP_ADD,     8'd9,   16'd100,  1'b1, outcome(ST_ADDED, 8'd0, 16'd0)},
            '{OP_ADD,     8'd255, 16'd50,   1'b1, outcome(ST_REPLACED, 8'd0, 16'd0)},
            '{OP_EXTRACT, 8'hAA,  16'h5555, 1'b1, outcome(ST_EXTRACTED, 8'd0, 16'd0)},
            '{OP_EXTRACT, 8'd0,   16'd0,    1'b1, outcome(ST_EXTRACTED, 8'd255, 16'd50)},
            '{OP_EXTRACT, 8'd0,   16'd0,    1'b1, outcome(ST_EXTRACTED, 8'd7, 16'd100)},
            '{OP_EXTRACT, 8'd0,   16'd0,    1'b1, outcome(ST_EXTRACTED, 8'd9, 16'd100)},
            '{OP_EXTRACT, 8'd0,   16'd0,    1'b1, outcome(ST_EMPTY, 8'd0, 16'd0)}
        };
        foreach (rows[i])
            send_op(rows[i].op, rows[i].id, rows[i].key, rows[i].has_exp, rows[i].exp);

        // Fill to capacity, then a new id is dropped and a known id replaced.
        for (k = 0; k < CAP; k++)
            send_op(OP_ADD, 8'(k * 3), 16'($urandom_range(65535)), 1'b1,
                    outcome(ST_ADDED, 8'd0, 16'd0));
        send_op(OP_ADD, 8'd200, 16'd1, 1'b1, outcome(ST_DROPPED, 8'd0, 16'd0));
        send_op(OP_ADD, 8'd3, 16'd0, 1'b1, outcome(ST_REPLACED, 8'd0, 16'd0));
        send_op(OP_EXTRACT, 8'd0, 16'd0, 1'b0, '0);

        // Every mode, including the unused code three and both extremes.
        for (k = 0; k < 4; k++) begin
            mode_v = (k == 0) ? MODE_STACK : (k == 1) ? MODE_DESC :
                     (k == 2) ? 2'd3 : MODE_ASC;
            set_mode(mode_v);
            for (n = 0; n < 6; n++)
                send_op(OP_ADD, 8'($urandom_range(255)), 16'($urandom_range(3)), 1'b0, '0);
            for (n = 0; n < 4; n++)
                send_op(OP_EXTRACT, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                        1'b0, '0);
        end

        // Random part: phases in random modes; small id sets make duplicates
        // and a full queue common, small key sets make ties common.
        for (n = 0; n < 1300; n++) begin
            if (n % 130 == 0) begin
                mode_v = 2'($urandom_range(3));
                set_mode(mode_v);
                idle_free = (n == 390);
                id_span   = (n % 260 == 0) ? 255 : 40;
            end
            if (n == 700) hold_sink = 1'b1;
            op  = ($urandom_range(99) < 40) ? OP_EXTRACT : OP_ADD;
            id  = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                           : 8'($urandom_range(id_span));
            key = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                           : 16'($urandom_range(15));
            send_op(op, id, key, 1'b0, '0);
        end

        drain();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
